/* hdl/smbc_pkg.sv */
package smbc_pkg;

   localparam int NUM_CS     = 4;
   localparam int DIV_WIDTH  = 16;
   localparam int WORD_WIDTH = 8;
   localparam int BIT_CNT_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [BIT_CNT_W-1:0] BITS_PER_WORD = BIT_CNT_W'(WORD_WIDTH);

   // status word bit positions
   localparam int STAT_BUSY     = 0;
   localparam int STAT_TX_EMPTY = 1;
   localparam int STAT_RX_READY = 2;

   typedef enum logic [1:0] {
      ACT_TICK        = 2'd0,
      ACT_WRITE       = 2'd1,
      ACT_READ_DATA   = 2'd2,
      ACT_READ_STATUS = 2'd3
   } action_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ENABLE    = 3'd0,
      REG_SPI_MODE  = 3'd1,
      REG_LOOPBACK  = 3'd2,
      REG_CLOCK_DIV = 3'd3,
      REG_CS_MASK   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                 enable;
      logic [1:0]           spi_mode;
      logic                 loopback;
      logic [DIV_WIDTH-1:0] clock_divider;
      logic [NUM_CS-1:0]    chip_select_mask;
   } cfg_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_data;
      logic                  sck;
      logic                  mosi;
      logic [NUM_CS-1:0]     cs_n;
      logic                  busy_res;
   } rsp_type;

endpackage

/* hdl/smbc_csr.sv */
module smbc_csr
   import smbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_ENABLE:    cfg_in.enable           = pwdata[0];
            REG_SPI_MODE:  cfg_in.spi_mode         = pwdata[1:0];
            REG_LOOPBACK:  cfg_in.loopback         = pwdata[0];
            REG_CLOCK_DIV: cfg_in.clock_divider    = pwdata[DIV_WIDTH-1:0];
            REG_CS_MASK:   cfg_in.chip_select_mask = pwdata[NUM_CS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_ENABLE:    prdata = CSR_DATA_W'(cfg_ff.enable);
         REG_SPI_MODE:  prdata = CSR_DATA_W'(cfg_ff.spi_mode);
         REG_LOOPBACK:  prdata = CSR_DATA_W'(cfg_ff.loopback);
         REG_CLOCK_DIV: prdata = CSR_DATA_W'(cfg_ff.clock_divider);
         REG_CS_MASK:   prdata = CSR_DATA_W'(cfg_ff.chip_select_mask);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/smbc_engine.sv */
module smbc_engine
   import smbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  step,
   input  action_type            action,
   input  logic [WORD_WIDTH-1:0] tx_byte,
   input  logic                  miso,
   output rsp_type               rsp
);

   logic [WORD_WIDTH-1:0] tx_ff, tx_in, rx_ff, rx_in, hold_ff, hold_in;
   logic [BIT_CNT_W-1:0]  bit_ff, bit_in, bit_inc;
   logic [DIV_WIDTH-1:0]  hp_ff, hp_in;
   logic                  sck_ff, sck_in, busy_ff, busy_in, rdy_ff, rdy_in;
   logic                  cpol, cpha, leading, in_bit, started;
   logic [WORD_WIDTH-1:0] rd;

   assign cpol = cfg.spi_mode[0];
   assign cpha = cfg.spi_mode[1];

   always_comb begin
      tx_in   = tx_ff;
      rx_in   = rx_ff;
      hold_in = hold_ff;
      bit_in  = bit_ff;
      bit_inc = bit_ff + 1'b1;
      hp_in   = hp_ff;
      sck_in  = sck_ff;
      rdy_in  = rdy_ff;
      // clearing enable aborts a byte in flight
      busy_in = busy_ff & cfg.enable;
      rd      = '0;
      started = 1'b0;
      leading = (sck_ff == cpol);
      in_bit  = cfg.loopback ? tx_ff[WORD_WIDTH-1] : miso;

      case (action)
         ACT_WRITE: begin
            if (cfg.enable && !busy_in) begin
               tx_in   = tx_byte;
               rx_in   = '0;
               bit_in  = '0;
               hp_in   = '0;
               sck_in  = cpol;
               busy_in = 1'b1;
               started = 1'b1;
            end
         end
         ACT_READ_DATA: begin
            rd     = hold_ff;
            rdy_in = 1'b0;
         end
         ACT_READ_STATUS: begin
            rd[STAT_BUSY]     = busy_in;
            rd[STAT_TX_EMPTY] = ~busy_in;
            rd[STAT_RX_READY] = rdy_ff;
         end
         default: ;
      endcase

      if (busy_in && !started) begin
         if (hp_ff != cfg.clock_divider) begin
            hp_in = hp_ff + 1'b1;
         end else begin
            hp_in  = '0;
            sck_in = ~sck_ff;
            if (cpha ? !leading : leading) begin
               rx_in = {rx_ff[WORD_WIDTH-2:0], in_bit};
            end
            if ((!cpha && !leading) || (cpha && leading && bit_ff != '0)) begin
               tx_in = {tx_ff[WORD_WIDTH-2:0], 1'b0};
            end
            if (!leading) begin
               bit_in = bit_inc;
               if (bit_inc >= BITS_PER_WORD) begin
                  hold_in = rx_in;
                  rdy_in  = 1'b1;
                  busy_in = 1'b0;
                  bit_in  = '0;
                  sck_in  = cpol;
               end
            end
         end
      end
   end

   always_comb begin
      rsp.read_data = rd;
      rsp.sck       = busy_in ? sck_in : cpol;
      rsp.mosi      = tx_in[WORD_WIDTH-1];
      rsp.cs_n      = ~cfg.chip_select_mask;
      rsp.busy_res  = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff   <= '0;
         rx_ff   <= '0;
         hold_ff <= '0;
         bit_ff  <= '0;
         hp_ff   <= '0;
         sck_ff  <= 1'b0;
         busy_ff <= 1'b0;
         rdy_ff  <= 1'b0;
      end else if (step) begin
         tx_ff   <= tx_in;
         rx_ff   <= rx_in;
         hold_ff <= hold_in;
         bit_ff  <= bit_in;
         hp_ff   <= hp_in;
         sck_ff  <= sck_in;
         busy_ff <= busy_in;
         rdy_ff  <= rdy_in;
      end
   end

endmodule

/* hdl/spi_master_byte_controller.sv */
// Channel  | Direction | Handshake              | Beat
// req      | in        | req_valid / req_stall  | action, tx_byte, miso
// rsp      | out       | rsp_valid / rsp_stall  | read_data, sck, mosi, cs_n, busy_res
// csr      | in/out    | APB, pready always 1   | 32-bit registers at 4*index
//
// One req beat per cycle while req_stall is low, one rsp beat per req beat; each beat passes
// an input register, then the tick logic into the result register.
// Synchronous active-high reset clears the control registers and all settings.
// A stalled rsp holds the result register; the input register still takes one
// beat, then req_stall rises until the result register drains.
module spi_master_byte_controller
   import smbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [WORD_WIDTH-1:0] req_tx_byte,
   input  logic                  req_miso,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_WIDTH-1:0] rsp_read_data,
   output logic                  rsp_sck,
   output logic                  rsp_mosi,
   output logic [NUM_CS-1:0]     rsp_cs_n,
   output logic                  rsp_busy_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type               cfg;
   rsp_type               rsp_next;
   rsp_type               out_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  s1_valid_ff, s1_valid_in;
   action_type            s1_action_ff;
   logic [WORD_WIDTH-1:0] s1_tx_byte_ff;
   logic                  s1_miso_ff;
   logic                  out_load, step, req_take;

   smbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   smbc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .action  (s1_action_ff),
      .tx_byte (s1_tx_byte_ff),
      .miso    (s1_miso_ff),
      .rsp     (rsp_next)
   );

   assign out_load     = ~out_valid_ff | ~rsp_stall;
   assign step         = s1_valid_ff & out_load;
   assign req_stall    = s1_valid_ff & ~out_load;
   assign req_take     = req_valid & ~req_stall;
   assign s1_valid_in  = req_take | (s1_valid_ff & ~step);
   assign out_valid_in = step | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff  <= action_type'(req_action);
         s1_tx_byte_ff <= req_tx_byte;
         s1_miso_ff    <= req_miso;
      end
      if (step) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_sck       = out_ff.sck;
   assign rsp_mosi      = out_ff.mosi;
   assign rsp_cs_n      = out_ff.cs_n;
   assign rsp_busy_res  = out_ff.busy_res;

endmodule

/* hdl/smbc_checker.sv */
module smbc_checker
   import smbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WORD_WIDTH-1:0] rsp_read_data,
   input logic                  rsp_sck,
   input logic                  rsp_mosi,
   input logic [NUM_CS-1:0]     rsp_cs_n,
   input logic                  rsp_busy_res
);

   // held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_sck)
         && $stable(rsp_mosi) && $stable(rsp_cs_n) && $stable(rsp_busy_res))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with the result register empty the input side must never be held off
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall with empty result register");

endmodule

bind spi_master_byte_controller smbc_checker u_smbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_data (rsp_read_data),
   .rsp_sck       (rsp_sck),
   .rsp_mosi      (rsp_mosi),
   .rsp_cs_n      (rsp_cs_n),
   .rsp_busy_res  (rsp_busy_res)
);

/* verif/tb_top.sv */
module tb_top;
   import smbc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_BEATS = 1800;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = ACT_TICK;
   logic [WORD_WIDTH-1:0] req_tx_byte = '0;
   logic                  req_miso = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_read_data;
   logic                  rsp_sck;
   logic                  rsp_mosi;
   logic [NUM_CS-1:0]     rsp_cs_n;
   logic                  rsp_busy_res;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spi_master_byte_controller uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_tx_byte   (req_tx_byte),
      .req_miso      (req_miso),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_sck       (rsp_sck),
      .rsp_mosi      (rsp_mosi),
      .rsp_cs_n      (rsp_cs_n),
      .rsp_busy_res  (rsp_busy_res),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #10 clock = ~clock;

   // shadow settings
   logic                  cfg_enable = 1'b0;
   logic [1:0]            cfg_mode = 2'b00;
   logic                  cfg_loop = 1'b0;
   logic [DIV_WIDTH-1:0]  cfg_div = '0;
   logic [NUM_CS-1:0]     cfg_cs = '0;

   // shadow shift engine
   logic [WORD_WIDTH-1:0] sh_tx = '0;
   logic [WORD_WIDTH-1:0] sh_rx = '0;
   logic [WORD_WIDTH-1:0] rx_hold = '0;
   logic [BIT_CNT_W-1:0]  bit_cnt = '0;
   logic [DIV_WIDTH-1:0]  half_cnt = '0;
   logic                  sck_lvl = 1'b0;
   logic                  busy = 1'b0;
   logic                  rcv_full = 1'b0;

   rsp_type expected_rsp[$];

   int  beats_sent = 0;
   int  beats_checked = 0;
   int  bytes_done = 0;
   int  aborts = 0;
   int  errors = 0;
   int  cycle_count = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   int  rsp_hold_req = 0;

   task automatic report(string what, int got, int want);
      errors++;
      if (errors <= 40)
         $display("mismatch at result %0d: %s got %0h want %0h", beats_checked, what, got, want);
   endtask

   function automatic void end_byte();
      busy     = 1'b0;
      sck_lvl  = cfg_mode[0];
      bit_cnt  = '0;
      half_cnt = '0;
   endfunction

   function automatic rsp_type predict_tick(action_type act, logic [7:0] txb, logic miso_in);
      rsp_type               r;
      logic [WORD_WIDTH-1:0] rd;
      logic                  started;
      logic                  cpol;
      logic                  cpha;
      logic                  in_bit;
      logic                  lead;
      cpol    = cfg_mode[0];
      cpha    = cfg_mode[1];
      rd      = '0;
      started = 1'b0;
      if (!cfg_enable && busy) begin
         end_byte();
         aborts++;
      end
      case (act)
         ACT_WRITE: begin
            if (cfg_enable && !busy) begin
               sh_tx    = txb;
               sh_rx    = '0;
               bit_cnt  = '0;
               half_cnt = '0;
               sck_lvl  = cpol;
               busy     = 1'b1;
               started  = 1'b1;
            end
         end
         ACT_READ_DATA: begin
            rd       = rx_hold;
            rcv_full = 1'b0;
         end
         ACT_READ_STATUS: begin
            rd[STAT_BUSY]     = busy;
            rd[STAT_TX_EMPTY] = ~busy;
            rd[STAT_RX_READY] = rcv_full;
         end
         default: ;
      endcase
      // a byte started this tick does not advance until the next one
      if (busy && !started) begin
         in_bit = cfg_loop ? sh_tx[7] : miso_in;
         if (half_cnt != cfg_div) begin
            half_cnt = half_cnt + 1'b1;
         end else begin
            half_cnt = '0;
            lead     = (sck_lvl == cpol);
            sck_lvl  = lead ? ~cpol : cpol;
            if (cpha ? !lead : lead)
               sh_rx = {sh_rx[6:0], in_bit};
            if (!cpha ? !lead : (lead && bit_cnt != 0))
               sh_tx = {sh_tx[6:0], 1'b0};
            if (!lead) begin
               bit_cnt = bit_cnt + 1'b1;
               if (bit_cnt >= BITS_PER_WORD) begin
                  rx_hold  = sh_rx;
                  rcv_full = 1'b1;
                  bytes_done++;
                  end_byte();
               end
            end
         end
      end
      r.read_data = rd;
      r.sck       = busy ? sck_lvl : cpol;
      r.mosi      = sh_tx[7];
      r.cs_n      = ~cfg_cs;
      r.busy_res  = busy;
      return r;
   endfunction

   task automatic send_beat(action_type act, logic [7:0] txb, logic miso_in);
      int gap;
      int unsigned pick;
      req_valid   <= 1'b1;
      req_action  <= act;
      req_tx_byte <= txb;
      req_miso    <= miso_in;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(predict_tick(act, txb, miso_in));
      beats_sent++;
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (req_gaps_on) begin
         if (pick >= 92)
            gap = $urandom_range(8, 40);
         else if (pick >= 60)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write, then read it back; only while the pipeline is empty
   task automatic set_reg(reg_index_type idx, logic [31:0] value);
      logic [31:0] kept;
      settle();
      kept        = '0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ENABLE: begin
            cfg_enable = value[0];
            kept[0]    = value[0];
         end
         REG_SPI_MODE: begin
            cfg_mode  = value[1:0];
            kept[1:0] = value[1:0];
         end
         REG_LOOPBACK: begin
            cfg_loop = value[0];
            kept[0]  = value[0];
         end
         REG_CLOCK_DIV: begin
            cfg_div              = value[DIV_WIDTH-1:0];
            kept[DIV_WIDTH-1:0]  = value[DIV_WIDTH-1:0];
         end
         REG_CS_MASK: begin
            cfg_cs            = value[NUM_CS-1:0];
            kept[NUM_CS-1:0]  = value[NUM_CS-1:0];
         end
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== kept)
         report("register readback", csr_prdata, kept);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receiver: random stall runs, plus a long hold-off on request
   always @(posedge clock) begin
      int unsigned pick;
      int          stall_left;
      int          run_left;
      int          hold_seen;
      if (rsp_hold_req != hold_seen) begin
         hold_seen  = rsp_hold_req;
         stall_left = 200;
         run_left   = 0;
      end
      if (stall_left == 0 && run_left == 0 && rsp_gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            run_left = $urandom_range(1, 30);
         else if (pick < 93)
            stall_left = $urandom_range(1, 3);
         else
            stall_left = $urandom_range(10, 50);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (run_left > 0)
            run_left--;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report("result with nothing pending", 0, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_read_data !== want.read_data)
               report("read_data", rsp_read_data, want.read_data);
            if (rsp_sck !== want.sck)
               report("sck", rsp_sck, want.sck);
            if (rsp_mosi !== want.mosi)
               report("mosi", rsp_mosi, want.mosi);
            if (rsp_cs_n !== want.cs_n)
               report("cs_n", rsp_cs_n, want.cs_n);
            if (rsp_busy_res !== want.busy_res)
               report("busy_res", rsp_busy_res, want.busy_res);
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_rsp.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic test_after_reset();
      send_beat(ACT_READ_STATUS, 8'h00, 1'b0);
      send_beat(ACT_READ_DATA, 8'hFF, 1'b1);
      send_beat(ACT_TICK, 8'h00, 1'b0);
      // disabled: write must not start a byte
      send_beat(ACT_WRITE, 8'hA5, 1'b1);
      send_beat(ACT_READ_STATUS, 8'h00, 1'b0);
   endtask

   task automatic test_registers();
      // junk above each register's width is dropped
      set_reg(REG_ENABLE, 32'hFFFF_FFFE);
      set_reg(REG_SPI_MODE, 32'hFFFF_FFFF);
      set_reg(REG_LOOPBACK, 32'h8000_0001);
      set_reg(REG_CLOCK_DIV, 32'hFFFF_FFFF);
      set_reg(REG_CS_MASK, 32'hFFFF_FFF0);
      set_reg(REG_CS_MASK, 32'h0000_000F);
   endtask

   task automatic test_directed_bytes();
      set_reg(REG_ENABLE, 32'h1);
      set_reg(REG_SPI_MODE, 32'h0);
      set_reg(REG_LOOPBACK, 32'h0);
      set_reg(REG_CLOCK_DIV, 32'h0);
      send_beat(ACT_WRITE, 8'hFF, 1'b1);
      for (int i = 0; i < 16; i++) begin
         if (i == 3)
            send_beat(ACT_READ_STATUS, 8'h00, 1'b1);
         else if (i == 5)
            send_beat(ACT_WRITE, 8'h00, 1'b1);     // busy: ignored
         else if (i == 8)
            send_beat(ACT_READ_DATA, 8'h00, 1'b1); // clears ready mid-byte
         else
            send_beat(ACT_TICK, 8'h00, 1'b1);
      end
      send_beat(ACT_READ_STATUS, 8'h00, 1'b0);
      send_beat(ACT_READ_DATA, 8'h00, 1'b0);

      // slowest divider, then lower it and change mode mid-byte, then abort
      set_reg(REG_SPI_MODE, 32'h3);
      set_reg(REG_LOOPBACK, 32'h1);
      set_reg(REG_CLOCK_DIV, 32'h0000_FFFF);
      send_beat(ACT_WRITE, 8'h00, 1'b1);
      repeat (3) send_beat(ACT_TICK, 8'hFF, 1'b1);
      send_beat(ACT_READ_STATUS, 8'h00, 1'b0);
      set_reg(REG_CLOCK_DIV, 32'h0);
      set_reg(REG_SPI_MODE, 32'h1);
      repeat (4) send_beat(ACT_TICK, 8'h00, 1'b0);
      set_reg(REG_ENABLE, 32'h0);
      send_beat(ACT_TICK, 8'h00, 1'b0);
      send_beat(ACT_READ_STATUS, 8'h00, 1'b0);
      send_beat(ACT_READ_DATA, 8'h00, 1'b0);
      set_reg(REG_ENABLE, 32'h1);
   endtask

   task automatic test_backpressure();
      set_reg(REG_ENABLE, 32'h1);
      set_reg(REG_CLOCK_DIV, 32'h0);
      req_gaps_on = 1'b0;
      rsp_hold_req++;
      send_beat(ACT_WRITE, 8'h5A, 1'b0);
      for (int i = 0; i < 40; i++)
         send_beat(action_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      req_gaps_on = 1'b1;
      // sender waits for every result before going on
      settle();
   endtask

   task automatic test_random();
      int          target;
      int          n;
      int          cap;
      int unsigned pick;
      logic [31:0] v;
      reg_index_type idx;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            idx = reg_index_type'($urandom_range(0, 4));
            v   = $urandom;
            pick = $urandom_range(0, 99);
            if (idx == REG_ENABLE)
               v[0] = ($urandom_range(0, 9) != 0);
            else if (idx == REG_CLOCK_DIV)
               v[DIV_WIDTH-1:0] = DIV_WIDTH'((pick < 50) ? $urandom_range(0, 1) :
                                  (pick < 85) ? $urandom_range(2, 4) : $urandom_range(5, 12));
            set_reg(idx, v);
         end
         if (!cfg_enable && $urandom_range(0, 1))
            set_reg(REG_ENABLE, 32'h1);
         // counter past a lowered divider would wrap through 64k ticks: abort instead
         if (busy && half_cnt > cfg_div) begin
            set_reg(REG_ENABLE, 32'h0);
            send_beat(ACT_TICK, 8'h00, 1'b0);
            set_reg(REG_ENABLE, 32'h1);
         end
         n = $urandom_range(1, 3);
         for (int t = 0; t < n; t++) begin
            if ($urandom_range(0, 99) < 80) begin
               send_beat(ACT_WRITE, 8'($urandom), 1'($urandom));
               cap = 16 * (int'(cfg_div) + 1) + 4;
               if ($urandom_range(0, 9) == 0)
                  cap = $urandom_range(1, cap);
               while (busy && cap > 0) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 85)
                     send_beat(ACT_TICK, 8'($urandom), 1'($urandom));
                  else if (pick < 92)
                     send_beat(ACT_READ_STATUS, 8'($urandom), 1'($urandom));
                  else if (pick < 96)
                     send_beat(ACT_READ_DATA, 8'($urandom), 1'($urandom));
                  else
                     send_beat(ACT_WRITE, 8'($urandom), 1'($urandom));
                  cap--;
               end
               if ($urandom_range(0, 2) == 0)
                  send_beat(ACT_READ_STATUS, 8'($urandom), 1'($urandom));
               send_beat(ACT_READ_DATA, 8'($urandom), 1'($urandom));
            end else begin
               repeat ($urandom_range(1, 8))
                  send_beat(action_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_registers();
      test_directed_bytes();
      test_backpressure();
      test_random();
      settle();
      repeat (10) @(posedge clock);
      $display("%0d beats sent, %0d results checked, %0d bytes shifted, %0d aborted",
               beats_sent, beats_checked, bytes_done, aborts);
      $display("all SPI modes, loopback, divider 0..65535, stalls on both channels");
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
